@@ rtl/kiht_pkg.sv @@
// Shared types and codes for the keyed id hash table.
package kiht_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT   = 3'd0,
        ACT_LOOKUP   = 3'd1,
        ACT_TYPED    = 3'd2,
        ACT_ADD_REF  = 3'd3,
        ACT_DROP_REF = 3'd4,
        ACT_DELETE   = 3'd5,
        ACT_MARK     = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_EXISTS     = 3'd2,
        ST_REFS_HELD  = 3'd3,
        ST_DELETED    = 3'd4,
        ST_WRONG_TYPE = 3'd5,
        ST_REFS_LIMIT = 3'd6,
        ST_TABLE_FULL = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_CMP,
        S_DECIDE,
        S_FREE_RD,
        S_INS_W1,
        S_INS_W2,
        S_DEL_W2
    } state_t;

    // Per-slot payload: 53 bits.
    typedef struct packed {
        logic        del;
        logic [15:0] refs;
        logic [3:0]  etype;
        logic [31:0] iid;
    } info_t;

    typedef struct packed {
        logic key;
        logic info;
        logic link;
    } slot_we_t;

endpackage

@@ rtl/kiht_req_if.sv @@
// Request channel of the keyed id hash table.
interface kiht_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         name_space;
    logic [63:0]        key;
    logic [3:0]         entry_type;
    logic [31:0]        entry_iid;
    logic signed [15:0] given_refs;
    logic               use_given_refs;
    logic               assign_id;

    modport source (
        output valid, action, name_space, key, entry_type, entry_iid, given_refs,
               use_given_refs, assign_id,
        input  ready
    );
    modport sink (
        input  valid, action, name_space, key, entry_type, entry_iid, given_refs,
               use_given_refs, assign_id,
        output ready
    );
endinterface

@@ rtl/kiht_rsp_if.sv @@
// Response channel of the keyed id hash table.
interface kiht_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [31:0]        found_iid;
    logic [3:0]         found_type;
    logic signed [15:0] found_refs;
    logic               found_deleted;

    modport source (
        output valid, status, found_iid, found_type, found_refs, found_deleted,
        input  ready
    );
    modport sink (
        input  valid, status, found_iid, found_type, found_refs, found_deleted,
        output ready
    );
endinterface

@@ rtl/keyed_id_hash_table.sv @@
// Keyed id hash table: top level with bucket heads, free list, id counters and control.
//
// After reset the block clears all BUCKETS bucket heads, one a cycle, and takes no
// request during that pass. A request then walks its chain one entry per cycle, as
// the slot memory read port is the walk's bottleneck. The response is registered in
// S_DECIDE, which waits while the response register is still full. Insert write-back
// and a delete's unlink of a non-head entry follow the response. An insert writes in
// S_INS_W1, then S_INS_W2 if not at the chain head, after S_FREE_RD for a free-list
// slot. A delete of a non-head entry adds S_DEL_W2. One request is in work at a
// time. A finished response may wait in its register while the next request is taken.
module keyed_id_hash_table
    import kiht_pkg::*;
#(
    parameter int SLOTS      = 1024,
    parameter int BUCKETS    = 4096,
    parameter int TYPE_COUNT = 16,
    parameter int REFS_LIMIT = 32767
)
(
    input  logic       clk,
    input  logic       rst_n,
    kiht_req_if.sink   req,
    kiht_rsp_if.source rsp
);

    localparam int SA     = $clog2(SLOTS);
    localparam int SW     = $clog2(SLOTS + 1);
    localparam int BW     = $clog2(BUCKETS);
    localparam int CW     = $clog2(TYPE_COUNT);
    localparam int NCHUNK = (64 + BW - 1) / BW;
    localparam int LIM    = (REFS_LIMIT > 32768) ? 32768 : REFS_LIMIT;

    localparam logic [SW-1:0]        NIL   = SW'(SLOTS);
    localparam logic signed [17:0]   LIM_P = 18'(LIM);
    localparam logic signed [17:0]   LIM_N = -LIM_P;

    typedef logic [15:0][CW-1:0] ci_tab_t;

    function automatic ci_tab_t make_ci_tab();
        ci_tab_t tab;
        for (int i = 0; i < 16; i++)
        begin
            tab[i] = CW'(i % TYPE_COUNT);
        end
        return tab;
    endfunction

    localparam ci_tab_t CI_TAB = make_ci_tab();

    // control registers
    state_t        state_reg, state_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic          found_reg, found_next;
    logic [SW-1:0] free_head_reg, free_head_next;
    logic [SW-1:0] unused_reg, unused_next;
    logic          out_valid_reg, out_valid_next;
    logic [TYPE_COUNT-1:0] ctr_vld_reg, ctr_vld_next;

    // payload registers
    logic [2:0]    act_reg, act_next;
    logic [7:0]    ns_reg, ns_next;
    logic [63:0]   key_reg, key_next;
    logic [3:0]    type_reg, type_next;
    logic [31:0]   iid_reg, iid_next;
    logic [15:0]   given_reg, given_next;
    logic          use_given_reg, use_given_next;
    logic          assign_reg, assign_next;
    logic [BW-1:0] bucket_reg, bucket_next;
    logic [CW-1:0] ci_reg, ci_next;
    logic [31:0]   ctr_reg, ctr_next;
    logic [SW-1:0] link_reg, link_next;
    info_t         info_reg, info_next;
    info_t         new_info_reg, new_info_next;
    logic [SW-1:0] n_reg, n_next;
    status_t       out_status_reg, out_status_next;
    info_t         out_info_reg, out_info_next;

    // memories and their ports
    logic [SW-1:0] bucket_mem [BUCKETS];
    logic [SW-1:0] head_rd;
    logic          bkt_we;
    logic [BW-1:0] bkt_waddr;
    logic [SW-1:0] bkt_wdata;

    logic [31:0]   ctr_mem [TYPE_COUNT];
    logic [31:0]   ctr_rd;
    logic          ctr_we;
    logic [31:0]   ctr_inc;

    slot_we_t      slot_we;
    logic [SA-1:0] slot_raddr;
    logic [SA-1:0] slot_waddr;
    logic [SA-1:0] link_waddr;
    info_t         wr_info;
    logic [SW-1:0] wr_link;
    logic [63:0]   rd_key;
    logic [7:0]    rd_space;
    info_t         rd_info;
    logic [SW-1:0] rd_link;

    logic [BW-1:0] fold;
    logic [63:0]   chunk;
    logic [BW-1:0] hidx;
    logic          key_eq;
    logic          key_gt;
    logic          out_free;
    logic signed [17:0] refs_new;
    logic          refs_bad;
    info_t         ins_info;
    info_t         upd_info;

    kiht_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .clk       (clk),
        .rd_addr   (slot_raddr),
        .we        (slot_we),
        .wr_addr   (slot_waddr),
        .link_addr (link_waddr),
        .wr_key    (key_reg),
        .wr_space  (ns_reg),
        .wr_info   (wr_info),
        .wr_link   (wr_link),
        .rd_key    (rd_key),
        .rd_space  (rd_space),
        .rd_info   (rd_info),
        .rd_link   (rd_link)
    );

    // bucket index: xor fold of the key, then one reduction step
    always_comb
    begin
        fold  = '0;
        chunk = '0;
        for (int i = 0; i < NCHUNK; i++)
        begin
            chunk = req.key >> (i * BW);
            fold  = fold ^ chunk[BW-1:0];
        end
        if ({1'b0, fold} >= (BW + 1)'(BUCKETS))
        begin
            hidx = fold - BW'(BUCKETS);
        end
        else
        begin
            hidx = fold;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bucket_mem[bkt_waddr] <= bkt_wdata;
        end
        head_rd <= bucket_mem[hidx];
    end

    always_ff @(posedge clk)
    begin
        if (ctr_we)
        begin
            ctr_mem[ci_reg] <= ctr_inc;
        end
        ctr_rd <= ctr_mem[CI_TAB[req.entry_type]];
    end

    assign ctr_inc = ctr_reg + 32'd1;
    assign key_eq  = ({rd_space, rd_key} == {ns_reg, key_reg});
    assign key_gt  = ({ns_reg, key_reg} > {rd_space, rd_key});
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (state_reg)
            S_HEAD:   slot_raddr = head_rd[SA-1:0];
            S_CMP:    slot_raddr = rd_link[SA-1:0];
            S_DECIDE: slot_raddr = free_head_reg[SA-1:0];
            default:  slot_raddr = cur_reg[SA-1:0];
        endcase
    end

    // new reference count and its range check
    always_comb
    begin
        if (act_reg == ACT_INSERT)
        begin
            refs_new = use_given_reg ? {{2{given_reg[15]}}, given_reg} : 18'sd1;
        end
        else if (act_reg == ACT_ADD_REF)
        begin
            refs_new = {{2{info_reg.refs[15]}}, info_reg.refs} + 18'sd1;
        end
        else
        begin
            refs_new = {{2{info_reg.refs[15]}}, info_reg.refs} - 18'sd1;
        end
        refs_bad = (refs_new >= LIM_P) || (refs_new <= LIM_N);

        ins_info.del   = 1'b0;
        ins_info.refs  = refs_new[15:0];
        ins_info.etype = type_reg;
        ins_info.iid   = assign_reg ? ctr_inc : iid_reg;

        upd_info       = info_reg;
        upd_info.del   = 1'b0;
        upd_info.refs  = refs_new[15:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        found_next      = found_reg;
        free_head_next  = free_head_reg;
        unused_next     = unused_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        ctr_vld_next    = ctr_vld_reg;
        act_next        = act_reg;
        ns_next         = ns_reg;
        key_next        = key_reg;
        type_next       = type_reg;
        iid_next        = iid_reg;
        given_next      = given_reg;
        use_given_next  = use_given_reg;
        assign_next     = assign_reg;
        bucket_next     = bucket_reg;
        ci_next         = ci_reg;
        ctr_next        = ctr_reg;
        link_next       = link_reg;
        info_next       = info_reg;
        new_info_next   = new_info_reg;
        n_next          = n_reg;
        out_status_next = out_status_reg;
        out_info_next   = out_info_reg;

        bkt_we     = 1'b0;
        bkt_waddr  = bucket_reg;
        bkt_wdata  = n_reg;
        ctr_we     = 1'b0;
        slot_we    = '0;
        slot_waddr = n_reg[SA-1:0];
        link_waddr = n_reg[SA-1:0];
        wr_info    = new_info_reg;
        wr_link    = cur_reg;

        case (state_reg)
            S_CLEAR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                bkt_wdata = NIL;
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next       = req.action;
                    ns_next        = req.name_space;
                    key_next       = req.key;
                    type_next      = req.entry_type;
                    iid_next       = req.entry_iid;
                    given_next     = req.given_refs;
                    use_given_next = req.use_given_refs;
                    assign_next    = req.assign_id;
                    bucket_next    = hidx;
                    ci_next        = CI_TAB[req.entry_type];
                    state_next     = S_HEAD;
                end
            end

            S_HEAD:
            begin
                ctr_next   = ctr_vld_reg[ci_reg] ? ctr_rd : 32'd0;
                cur_next   = head_rd;
                prev_next  = NIL;
                found_next = 1'b0;
                state_next = (head_rd == NIL) ? S_DECIDE : S_CMP;
            end

            S_CMP:
            begin
                if (key_eq)
                begin
                    found_next = 1'b1;
                    info_next  = rd_info;
                    link_next  = rd_link;
                    state_next = S_DECIDE;
                end
                else if (key_gt)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    // chain is descending: keep walking
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    state_next = (rd_link == NIL) ? S_DECIDE : S_CMP;
                end
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_NOT_FOUND;
                    out_info_next   = '0;
                    state_next      = S_IDLE;
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            if (refs_bad)
                            begin
                                out_status_next = ST_REFS_LIMIT;
                            end
                            else if (found_reg)
                            begin
                                out_status_next = ST_EXISTS;
                                out_info_next   = info_reg;
                                ctr_we          = assign_reg;
                                ctr_vld_next[ci_reg] = ctr_vld_reg[ci_reg] || assign_reg;
                            end
                            else if (free_head_reg != NIL || unused_reg != NIL)
                            begin
                                out_status_next = ST_OK;
                                out_info_next   = ins_info;
                                new_info_next   = ins_info;
                                ctr_we          = assign_reg;
                                ctr_vld_next[ci_reg] = ctr_vld_reg[ci_reg] || assign_reg;
                                if (free_head_reg != NIL)
                                begin
                                    n_next     = free_head_reg;
                                    state_next = S_FREE_RD;
                                end
                                else
                                begin
                                    n_next      = unused_reg;
                                    unused_next = unused_reg + 1'b1;
                                    state_next  = S_INS_W1;
                                end
                            end
                            else
                            begin
                                out_status_next = ST_TABLE_FULL;
                            end
                        end

                        ACT_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                out_status_next = ST_OK;
                                out_info_next   = info_reg;
                            end
                        end

                        ACT_TYPED:
                        begin
                            if (found_reg)
                            begin
                                out_info_next = info_reg;
                                if (info_reg.del)
                                begin
                                    out_status_next = ST_DELETED;
                                end
                                else if (info_reg.etype != type_reg)
                                begin
                                    out_status_next = ST_WRONG_TYPE;
                                end
                                else
                                begin
                                    out_status_next = ST_OK;
                                end
                            end
                        end

                        ACT_ADD_REF, ACT_DROP_REF:
                        begin
                            if (found_reg)
                            begin
                                if (info_reg.del)
                                begin
                                    out_status_next = ST_DELETED;
                                    out_info_next   = info_reg;
                                end
                                else if (refs_bad)
                                begin
                                    out_status_next = ST_REFS_LIMIT;
                                end
                                else
                                begin
                                    out_status_next = ST_OK;
                                    out_info_next   = upd_info;
                                    slot_we.info    = 1'b1;
                                    slot_waddr      = cur_reg[SA-1:0];
                                    wr_info         = upd_info;
                                end
                            end
                        end

                        ACT_DELETE, ACT_MARK:
                        begin
                            if (found_reg)
                            begin
                                out_info_next = info_reg;
                                if (info_reg.refs != 16'd1)
                                begin
                                    out_status_next = ST_REFS_HELD;
                                end
                                else
                                begin
                                    out_status_next    = ST_OK;
                                    out_info_next.refs = '0;
                                    wr_info            = info_reg;
                                    wr_info.refs       = '0;
                                    slot_we.info       = 1'b1;
                                    slot_waddr         = cur_reg[SA-1:0];
                                    if (act_reg == ACT_MARK)
                                    begin
                                        out_info_next.del = 1'b1;
                                        wr_info.del       = 1'b1;
                                    end
                                    else
                                    begin
                                        // unlink the entry and push the slot on the free list
                                        slot_we.link   = 1'b1;
                                        link_waddr     = cur_reg[SA-1:0];
                                        wr_link        = free_head_reg;
                                        free_head_next = cur_reg;
                                        if (prev_reg == NIL)
                                        begin
                                            bkt_we    = 1'b1;
                                            bkt_wdata = link_reg;
                                        end
                                        else
                                        begin
                                            state_next = S_DEL_W2;
                                        end
                                    end
                                end
                            end
                        end

                        default:
                        begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_FREE_RD:
            begin
                free_head_next = rd_link;
                state_next     = S_INS_W1;
            end

            S_INS_W1:
            begin
                slot_we = '{key: 1'b1, info: 1'b1, link: 1'b1};
                wr_link = cur_reg;
                if (prev_reg == NIL)
                begin
                    bkt_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_INS_W2;
                end
            end

            S_INS_W2:
            begin
                slot_we.link = 1'b1;
                link_waddr   = prev_reg[SA-1:0];
                wr_link      = n_reg;
                state_next   = S_IDLE;
            end

            S_DEL_W2:
            begin
                slot_we.link = 1'b1;
                link_waddr   = prev_reg[SA-1:0];
                wr_link      = link_reg;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            found_reg     <= 1'b0;
            free_head_reg <= NIL;
            unused_reg    <= '0;
            out_valid_reg <= 1'b0;
            ctr_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            found_reg     <= found_next;
            free_head_reg <= free_head_next;
            unused_reg    <= unused_next;
            out_valid_reg <= out_valid_next;
            ctr_vld_reg   <= ctr_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        ns_reg         <= ns_next;
        key_reg        <= key_next;
        type_reg       <= type_next;
        iid_reg        <= iid_next;
        given_reg      <= given_next;
        use_given_reg  <= use_given_next;
        assign_reg     <= assign_next;
        bucket_reg     <= bucket_next;
        ci_reg         <= ci_next;
        ctr_reg        <= ctr_next;
        link_reg       <= link_next;
        info_reg       <= info_next;
        new_info_reg   <= new_info_next;
        n_reg          <= n_next;
        out_status_reg <= out_status_next;
        out_info_reg   <= out_info_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found_iid     = out_info_reg.iid;
    assign rsp.found_type    = out_info_reg.etype;
    assign rsp.found_refs    = out_info_reg.refs;
    assign rsp.found_deleted = out_info_reg.del;

    a_free_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NIL && unused_reg <= NIL)
        else $error("free list or fresh slot pointer out of range");

    a_walk_not_nil: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> cur_reg != NIL)
        else $error("chain walk compares an empty link");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_REFS_LIMIT
                      || rsp.status == ST_TABLE_FULL)
        |-> rsp.found_iid == 32'd0 && rsp.found_refs == 16'sd0 && !rsp.found_deleted)
        else $error("result without entry carries entry fields");

    a_decide_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE && !out_free |=> state_reg == S_DECIDE)
        else $error("decision left while response register busy");

endmodule

@@ rtl/kiht_slot_mem.sv @@
// Slot storage: key and namespace, info word and chain link, one read port.
module kiht_slot_mem
    import kiht_pkg::*;
#(
    parameter int SLOTS = 1024
)
(
    input  logic                       clk,
    input  logic [$clog2(SLOTS)-1:0]   rd_addr,
    input  slot_we_t                   we,
    input  logic [$clog2(SLOTS)-1:0]   wr_addr,
    input  logic [$clog2(SLOTS)-1:0]   link_addr,
    input  logic [63:0]                wr_key,
    input  logic [7:0]                 wr_space,
    input  info_t                      wr_info,
    input  logic [$clog2(SLOTS+1)-1:0] wr_link,
    output logic [63:0]                rd_key,
    output logic [7:0]                 rd_space,
    output info_t                      rd_info,
    output logic [$clog2(SLOTS+1)-1:0] rd_link
);

    localparam int SW = $clog2(SLOTS + 1);

    logic [71:0]   key_mem  [SLOTS];
    info_t         info_mem [SLOTS];
    logic [SW-1:0] link_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we.key)
        begin
            key_mem[wr_addr] <= {wr_space, wr_key};
        end
        {rd_space, rd_key} <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.info)
        begin
            info_mem[wr_addr] <= wr_info;
        end
        rd_info <= info_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.link)
        begin
            link_mem[link_addr] <= wr_link;
        end
        rd_link <= link_mem[rd_addr];
    end

endmodule
